### rtl/core/fnpll_pkg.sv
`timescale 1ns / 1ps

package fnpll_pkg;

    localparam int unsigned FREQ_W    = 23;
    localparam int unsigned VCO_W     = 23;
    localparam int unsigned CHDIV_W   = 3;
    localparam int unsigned INT_N_W   = 7;
    localparam int unsigned FRAC_W    = 20;
    localparam int unsigned WORD_W    = 16;

    localparam int unsigned REF_KHZ_DEF = 122880;

    // band edges in kHz, lower bounds inclusive
    localparam logic [FREQ_W-1:0] F_DIV6_LO = 23'd700000;
    localparam logic [FREQ_W-1:0] F_DIV4_LO = 23'd887500;
    localparam logic [FREQ_W-1:0] F_DIV3_LO = 23'd1183334;
    localparam logic [FREQ_W-1:0] F_DIV2_LO = 23'd1775000;
    localparam logic [FREQ_W-1:0] F_DIV1_LO = 23'd3550000;
    localparam logic [FREQ_W-1:0] F_MAX     = 23'd4500000;

    localparam logic [FRAC_W-1:0] FRAC_SCALE = 20'd1000000;

    localparam logic [WORD_W-1:0] BUF_WORD_DIV64 = 16'h0421;
    localparam logic [WORD_W-1:0] BUF_WORD_DIV32 = 16'h0411;
    localparam logic [WORD_W-1:0] BUF_WORD_DIV1  = 16'h0011;
    localparam logic [WORD_W-1:0] MUX_WORD_DEF   = 16'h00CF;
    localparam logic [WORD_W-1:0] MUX_WORD_DIV1  = 16'h08CF;
    localparam logic [WORD_W-1:0] VCO_WORD_DEF   = 16'h0601;
    localparam logic [WORD_W-1:0] VCO_WORD_DIV1  = 16'h0401;

    // per-band settings that ride alongside the divider arithmetic
    typedef struct packed {
        logic               valid;
        logic [CHDIV_W-1:0] chan_div;
        logic               seg1_on;
        logic               seg2_enable;
        logic               seg2_on;
        logic [WORD_W-1:0]  buf_div_word;
        logic [WORD_W-1:0]  mux_word;
        logic [WORD_W-1:0]  vco_buf_word;
    } t_band;

endpackage

### rtl/core/frac_n_pll_divider_calc_unit.sv
`timescale 1ns / 1ps

// Fractional-N PLL divider calculator. Give a frequency in kHz on i_req_freq with
// start high; while busy is low the beat is taken and the result appears on the
// o_ ports with o_done high for one cycle once it has passed the pipeline. A new
// frequency may be started every cycle; the eight-stage pipeline (band decode,
// VCO multiply, reciprocal estimate and correction of N, then of the fraction)
// sets the latency. busy is high only during reset. The receiver cannot stall, so
// o_done must be captured when it is high. Out-of-band requests give
// o_valid_res low, zero dividers and flags, and the default register words.
module frac_n_pll_divider_calc_unit #(
    parameter int unsigned REF_KHZ = fnpll_pkg::REF_KHZ_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [fnpll_pkg::FREQ_W-1:0]    i_req_freq,
    output logic                            o_done,
    output logic                            o_valid_res,
    output logic [fnpll_pkg::CHDIV_W-1:0]   o_chan_div,
    output logic [fnpll_pkg::INT_N_W-1:0]   o_int_n,
    output logic [fnpll_pkg::FRAC_W-1:0]    o_frac_num,
    output logic                            o_seg1_on,
    output logic                            o_seg2_enable,
    output logic                            o_seg2_on,
    output logic [fnpll_pkg::WORD_W-1:0]    o_buf_div_word,
    output logic [fnpll_pkg::WORD_W-1:0]    o_mux_word,
    output logic [fnpll_pkg::WORD_W-1:0]    o_vco_buf_word
);
    import fnpll_pkg::*;

    logic               r_a_vld;
    logic [FREQ_W-1:0]  r_a_freq;
    t_band              r_a_band;
    t_band              n_band;
    t_band              w_out_band;

    assign busy = !i_rst_n;

    always_comb begin
        n_band              = '0;
        n_band.buf_div_word = BUF_WORD_DIV64;
        n_band.mux_word     = MUX_WORD_DEF;
        n_band.vco_buf_word = VCO_WORD_DEF;
        if (i_req_freq >= F_DIV6_LO && i_req_freq < F_DIV4_LO) begin
            n_band.valid       = 1'b1;
            n_band.chan_div    = 3'd6;
            n_band.seg1_on     = 1'b1;
            n_band.seg2_enable = 1'b1;
            n_band.seg2_on     = 1'b1;
        end else if (i_req_freq >= F_DIV4_LO && i_req_freq < F_DIV3_LO) begin
            n_band.valid       = 1'b1;
            n_band.chan_div    = 3'd4;
            n_band.seg2_enable = 1'b1;
            n_band.seg2_on     = 1'b1;
        end else if (i_req_freq >= F_DIV3_LO && i_req_freq < F_DIV2_LO) begin
            n_band.valid        = 1'b1;
            n_band.chan_div     = 3'd3;
            n_band.seg1_on      = 1'b1;
            n_band.buf_div_word = BUF_WORD_DIV32;
        end else if (i_req_freq >= F_DIV2_LO && i_req_freq < F_DIV1_LO) begin
            n_band.valid        = 1'b1;
            n_band.chan_div     = 3'd2;
            n_band.buf_div_word = BUF_WORD_DIV32;
        end else if (i_req_freq >= F_DIV1_LO && i_req_freq <= F_MAX) begin
            n_band.valid        = 1'b1;
            n_band.chan_div     = 3'd1;
            n_band.buf_div_word = BUF_WORD_DIV1;
            n_band.mux_word     = MUX_WORD_DIV1;
            n_band.vco_buf_word = VCO_WORD_DIV1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= start && !busy;
        end
        r_a_freq <= i_req_freq;
        r_a_band <= n_band;
    end

    fnpll_ndiv #(
        .REF_KHZ    (REF_KHZ)
    ) u_ndiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (r_a_vld),
        .i_freq     (r_a_freq),
        .i_band     (r_a_band),
        .o_vld      (o_done),
        .o_band     (w_out_band),
        .o_int_n    (o_int_n),
        .o_frac_num (o_frac_num)
    );

    assign o_valid_res    = w_out_band.valid;
    assign o_chan_div     = w_out_band.chan_div;
    assign o_seg1_on      = w_out_band.seg1_on;
    assign o_seg2_enable  = w_out_band.seg2_enable;
    assign o_seg2_on      = w_out_band.seg2_on;
    assign o_buf_div_word = w_out_band.buf_div_word;
    assign o_mux_word     = w_out_band.mux_word;
    assign o_vco_buf_word = w_out_band.vco_buf_word;

`ifndef SYNTHESIS
    a_beat_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##8 o_done)
        else $error("accepted beat gave no result after eight cycles");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, 8))
        else $error("result without an accepted beat");

    a_valid_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_valid_res == (o_chan_div != '0)))
        else $error("valid flag and channel divider disagree");

    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_valid_res) |-> (o_frac_num != '0 && o_frac_num <= FRAC_SCALE))
        else $error("fraction numerator out of range");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_valid_res) |-> (o_int_n == '0 && o_frac_num == '0))
        else $error("out-of-band result carries a divider");
`endif

endmodule

### rtl/core/fnpll_ndiv.sv
`timescale 1ns / 1ps

module fnpll_ndiv #(
    parameter int unsigned REF_KHZ = fnpll_pkg::REF_KHZ_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_vld,
    input  logic [fnpll_pkg::FREQ_W-1:0]     i_freq,
    input  fnpll_pkg::t_band                 i_band,
    output logic                             o_vld,
    output fnpll_pkg::t_band                 o_band,
    output logic [fnpll_pkg::INT_N_W-1:0]    o_int_n,
    output logic [fnpll_pkg::FRAC_W-1:0]     o_frac_num
);
    import fnpll_pkg::*;

    localparam int unsigned REF_W  = $clog2(REF_KHZ + 1);
    localparam int unsigned R2_W   = REF_W + 1;
    localparam longint unsigned VCO_MAX = (64'd1 << VCO_W) - 64'd1;
    localparam int unsigned Q_W    = $clog2(VCO_MAX / REF_KHZ + 1);
    localparam int unsigned QX_W   = (Q_W > INT_N_W) ? Q_W : INT_N_W;
    localparam logic [REF_W-1:0] REF_V = REF_W'(REF_KHZ);

    // N estimate: floor(vco * floor(2^K1/ref) / 2^K1) is exact or one low
    localparam int unsigned K1     = VCO_W + 1;
    localparam longint unsigned M1 = (64'd1 << K1) / REF_KHZ;
    localparam int unsigned M1_W   = $clog2(M1 + 1);
    localparam logic [M1_W-1:0] M1_V = M1_W'(M1);

    // fraction estimate: rem * floor(1e6 * 2^K2 / ref) / 2^K2, also at most one low
    localparam int unsigned K2     = REF_W;
    localparam longint unsigned C2 = (64'd1000000 << K2) / REF_KHZ;
    localparam int unsigned C2_W   = $clog2(C2 + 1);
    localparam logic [C2_W-1:0] C2_V = C2_W'(C2);
    localparam int unsigned X_W    = REF_W + FRAC_W;

    logic [6:0]             r_vld;
    t_band                  r_band [1:7];

    logic [VCO_W-1:0]       r1_vco;
    logic [VCO_W-1:0]       r2_vco;
    logic [Q_W-1:0]         r2_qe;
    logic [Q_W-1:0]         r3_qe;
    logic [R2_W-1:0]        r3_rem;
    logic [Q_W-1:0]         r4_q;
    logic [REF_W-1:0]       r4_rem;
    logic [Q_W-1:0]         r5_q;
    logic [FRAC_W-1:0]      r5_p;
    logic [X_W-1:0]         r5_x;
    logic [Q_W-1:0]         r6_q;
    logic [FRAC_W-1:0]      r6_p;
    logic [R2_W-1:0]        r6_r2;
    logic [INT_N_W-1:0]     r7_int_n;
    logic [FRAC_W-1:0]      r7_frac;

    logic [VCO_W+CHDIV_W-1:0] w_vco_full;
    logic [VCO_W+M1_W-1:0]    w_prod1;
    logic [VCO_W+M1_W-1:0]    w_sh1;
    logic [Q_W+REF_W-1:0]     w_qref;
    logic                     w_ge1;
    logic [REF_W+C2_W-1:0]    w_prod2;
    logic [REF_W+C2_W-1:0]    w_sh2;
    logic [X_W-1:0]           w_x;
    logic [X_W-1:0]           w_pref;
    logic                     w_ge2;
    logic [QX_W-1:0]          w_q_ext;
    logic [FRAC_W-1:0]        n_frac;

    assign w_vco_full = i_freq * i_band.chan_div;
    assign w_prod1    = r1_vco * M1_V;
    assign w_sh1      = w_prod1 >> K1;
    assign w_qref     = r2_qe * REF_V;
    assign w_ge1      = (r3_rem >= R2_W'(REF_V));
    assign w_prod2    = r4_rem * C2_V;
    assign w_sh2      = w_prod2 >> K2;
    assign w_x        = r4_rem * FRAC_SCALE;
    assign w_pref     = r5_p * REF_V;
    assign w_ge2      = (r6_r2 >= R2_W'(REF_V));
    assign w_q_ext    = QX_W'(r6_q);
    assign n_frac     = r6_p + FRAC_W'(w_ge2) + FRAC_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[5:0], i_vld};
        end

        r_band[1] <= i_band;
        for (int i = 2; i <= 7; i++) begin
            r_band[i] <= r_band[i-1];
        end

        // stage 1: VCO frequency (fits VCO_W in every band)
        r1_vco <= VCO_W'(w_vco_full);

        // stage 2: integer divider estimate
        r2_vco <= r1_vco;
        r2_qe  <= Q_W'(w_sh1);

        // stage 3: remainder against estimate, below twice the reference
        r3_qe  <= r2_qe;
        r3_rem <= R2_W'(r2_vco - VCO_W'(w_qref));

        // stage 4: one correction step
        r4_q   <= r3_qe + Q_W'(w_ge1);
        r4_rem <= w_ge1 ? REF_W'(r3_rem - R2_W'(REF_V)) : REF_W'(r3_rem);

        // stage 5: fraction estimate and scaled remainder
        r5_q <= r4_q;
        r5_p <= FRAC_W'(w_sh2);
        r5_x <= w_x;

        // stage 6: fraction remainder check
        r6_q  <= r5_q;
        r6_p  <= r5_p;
        r6_r2 <= R2_W'(r5_x - w_pref);

        // stage 7: result, zeroed outside the bands
        r7_int_n <= r_band[6].valid ? w_q_ext[INT_N_W-1:0] : '0;
        r7_frac  <= r_band[6].valid ? n_frac : '0;
    end

    assign o_vld      = r_vld[6];
    assign o_band     = r_band[7];
    assign o_int_n    = r7_int_n;
    assign o_frac_num = r7_frac;

endmodule
